@@ design/pts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
// The command codes, payload structs, FSM states and control/status bundles
// are used across the other files; pts_div uses only the step count.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

	localparam int TASK_COUNT_DEF = 8;
	localparam logic [9:0] MS_TO_US = 10'd1000;
	localparam logic [7:0] TICK_PERIOD_RST = 8'd1;
	localparam int DIV_STEPS = 32;

	typedef enum logic [2:0] {
		CMD_TICK        = 3'd0,
		CMD_PER_TICKS   = 3'd1,
		CMD_PER_US      = 3'd2,
		CMD_PER_MS      = 3'd3,
		CMD_SET_ACTIVE  = 3'd4,
		CMD_TAKE_RUN    = 3'd5,
		CMD_READ_ACTIVE = 3'd6
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [2:0]  task_index;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic run_now;
		logic task_active;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EXEC,
		ST_RD,
		ST_UPD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic exec;
		logic walk_rd;
		logic walk_upd;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic walk_last;
	} stat_t;

endpackage

`default_nettype wire

@@ design/pts_div.sv @@
// Restoring divider, 32-bit dividend by 8-bit divisor, one quotient bit a cycle.
// Uses pts_pkg for the step count. A zero divisor yields an all-ones quotient.
`timescale 1ns / 1ps
`default_nettype none

module pts_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic      [31:0] quotient,
	output logic             done
);

	localparam int CW = $clog2(pts_pkg::DIV_STEPS);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   q_q;
	logic [7:0]    rem_q;

	logic [8:0] shifted;
	logic [8:0] diff;
	logic       fits;

	assign shifted = {rem_q, q_q[31]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(pts_pkg::DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend bits out the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			q_q   <= {q_q[30:0], fits};
			rem_q <= fits ? diff[7:0] : shifted[7:0];
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

`default_nettype wire

@@ design/pts_ctrl.sv @@
// Controller FSM for the tick scheduler: sequences accept, conversion,
// command execution and the per-task tick walk. Uses pts_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire pts_pkg::cmd_t command,
	input  wire pts_pkg::stat_t stat,
	output pts_pkg::ctl_t     ctl,
	output logic              busy
);

	pts_pkg::state_t state_q;
	pts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		case (state_q)
			pts_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					case (command)
						pts_pkg::CMD_TICK:   state_d = pts_pkg::ST_RD;
						pts_pkg::CMD_PER_US: state_d = pts_pkg::ST_PREP;
						pts_pkg::CMD_PER_MS: state_d = pts_pkg::ST_PREP;
						default:             state_d = pts_pkg::ST_EXEC;
					endcase
				end
			end
			pts_pkg::ST_PREP: begin
				ctl.div_start = 1'b1;
				state_d       = pts_pkg::ST_DIV;
			end
			pts_pkg::ST_DIV: begin
				if (stat.div_done) begin
					state_d = pts_pkg::ST_EXEC;
				end
			end
			pts_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = pts_pkg::ST_IDLE;
			end
			pts_pkg::ST_RD: begin
				ctl.walk_rd = 1'b1;
				state_d     = pts_pkg::ST_UPD;
			end
			pts_pkg::ST_UPD: begin
				ctl.walk_upd = 1'b1;
				state_d      = stat.walk_last ? pts_pkg::ST_IDLE : pts_pkg::ST_RD;
			end
			default: begin
				state_d = pts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/pts_dp.sv @@
// Datapath for the tick scheduler: task flags, countdown/reload memory,
// unit conversion (multiply and pts_div) and the result register. Uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_dp #(
	parameter int TASK_COUNT = pts_pkg::TASK_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pts_pkg::ctl_t ctl,
	output pts_pkg::stat_t     stat,
	input  wire pts_pkg::req_t request,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_data,
	output pts_pkg::res_t      result,
	output logic               done
);

	localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	pts_pkg::req_t   req_q;
	pts_pkg::res_t   result_q;
	logic            done_q;
	logic [7:0]      tick_q;
	logic [TASK_COUNT-1:0] active_q;
	logic [TASK_COUNT-1:0] pending_q;
	logic [TASK_COUNT-1:0] valid_q;
	logic [IW-1:0]   walk_q;

	// word = {reload, countdown}
	logic [63:0] mem [TASK_COUNT];
	logic [63:0] rd_q;
	logic        rd_valid_q;

	logic [IW+2:0] idx_ext;
	logic [IW-1:0] sel;
	logic          in_range;
	logic          walk_last;

	logic [31:0] prod;
	logic [31:0] dividend;
	logic [31:0] quot;
	logic        div_done;
	logic [31:0] per_ticks;
	logic [31:0] per_m1;
	logic        is_period;

	logic [31:0] cnt;
	logic [31:0] rel;
	logic        cnt_zero;

	logic        ex_run;
	logic        ex_act;

	logic        mem_we;
	logic [IW-1:0] mem_wa;
	logic [63:0] mem_wd;

	assign idx_ext   = {{IW{1'b0}}, req_q.task_index};
	assign sel       = idx_ext[IW-1:0];
	assign in_range  = (idx_ext < (IW+3)'(TASK_COUNT));
	assign walk_last = (walk_q == IW'(TASK_COUNT - 1));

	// milliseconds to microseconds, kept modulo 2^32
	assign prod     = req_q.value * 32'(pts_pkg::MS_TO_US);
	assign dividend = (req_q.command == pts_pkg::CMD_PER_MS) ? prod : req_q.value;

	pts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dividend),
		.divisor  (tick_q),
		.quotient (quot),
		.done     (div_done)
	);

	assign is_period = (req_q.command == pts_pkg::CMD_PER_TICKS)
	                || (req_q.command == pts_pkg::CMD_PER_US)
	                || (req_q.command == pts_pkg::CMD_PER_MS);
	assign per_ticks = (req_q.command == pts_pkg::CMD_PER_TICKS) ? req_q.value : quot;
	assign per_m1    = per_ticks - 32'd1;

	// an entry never written reads as zero
	assign cnt      = rd_valid_q ? rd_q[31:0]  : 32'd0;
	assign rel      = rd_valid_q ? rd_q[63:32] : 32'd0;
	assign cnt_zero = (cnt == 32'd0);

	always_comb begin
		ex_run = 1'b0;
		ex_act = in_range ? active_q[sel] : 1'b0;
		case (req_q.command)
			pts_pkg::CMD_PER_TICKS,
			pts_pkg::CMD_PER_US,
			pts_pkg::CMD_PER_MS:     ex_act = 1'b1;
			pts_pkg::CMD_SET_ACTIVE: ex_act = (req_q.value != 32'd0);
			pts_pkg::CMD_TAKE_RUN:   ex_run = in_range ? pending_q[sel] : 1'b0;
			default:                 ;
		endcase
		ex_run = ex_run & in_range;
		ex_act = ex_act & in_range;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = sel;
		mem_wd = {per_m1, per_m1};
		if (ctl.exec && is_period && in_range) begin
			mem_we = 1'b1;
		end else if (ctl.walk_upd && active_q[walk_q]) begin
			mem_we = 1'b1;
			mem_wa = walk_q;
			mem_wd = cnt_zero ? {rel, rel} : {rel, cnt - 32'd1};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (ctl.walk_rd) begin
			rd_q       <= mem[walk_q];
			rd_valid_q <= valid_q[walk_q];
		end
		if (ctl.load) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= pts_pkg::TICK_PERIOD_RST;
			active_q  <= '0;
			pending_q <= '0;
			valid_q   <= '0;
			walk_q    <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				tick_q <= cfg_data;
			end
			if (ctl.load) begin
				walk_q <= '0;
			end
			if (ctl.exec) begin
				done_q   <= 1'b1;
				result_q <= '{run_now: ex_run, task_active: ex_act};
				if (in_range) begin
					case (req_q.command)
						pts_pkg::CMD_PER_TICKS,
						pts_pkg::CMD_PER_US,
						pts_pkg::CMD_PER_MS: begin
							active_q[sel] <= 1'b1;
							valid_q[sel]  <= 1'b1;
						end
						pts_pkg::CMD_SET_ACTIVE: active_q[sel]  <= (req_q.value != 32'd0);
						pts_pkg::CMD_TAKE_RUN:   pending_q[sel] <= 1'b0;
						default:                 ;
					endcase
				end
			end
			if (ctl.walk_upd) begin
				if (active_q[walk_q]) begin
					valid_q[walk_q] <= 1'b1;
					if (cnt_zero) begin
						pending_q[walk_q] <= 1'b1;
					end
				end else begin
					pending_q[walk_q] <= 1'b0;
				end
				if (walk_last) begin
					done_q   <= 1'b1;
					result_q <= '0;
				end else begin
					walk_q <= walk_q + 1'b1;
				end
			end
		end
	end

	assign stat.div_done  = div_done;
	assign stat.walk_last = walk_last;
	assign result         = result_q;
	assign done           = done_q;

endmodule

`default_nettype wire

@@ design/periodic_task_tick_scheduler.sv @@
// Periodic task tick scheduler. Result is strobed on done in the cycle after the last work cycle.
// Set period in ticks, set/take/read flags: accept in IDLE, execute in EXEC, done back in IDLE.
// Period in us or ms: accept, PREP, DIV and EXEC, through the 32-step serial divider (one quotient bit a cycle).
// Tick: accept, then an RD and an UPD state per task, one memory read per task and one write per active task.
// Receiver cannot stall; the next start is taken in the cycle done is shown.
// Async reset clears flags and FSM, tick period resets to 1; countdowns read as zero until set.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler #(
	parameter int TASK_COUNT = pts_pkg::TASK_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pts_pkg::req_t request,
	output logic               done,
	output pts_pkg::res_t      result,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [7:0]    cfg_data
);

	pts_pkg::ctl_t  ctl;
	pts_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	pts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (stat),
		.ctl     (ctl),
		.busy    (busy)
	);

	pts_dp #(
		.TASK_COUNT (TASK_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.request  (request),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy)) |-> !done)
		else $error("result strobe without a transfer in progress");
`endif

endmodule

`default_nettype wire
